// ----- sv/g3wf_pkg.sv -----
// ----------------------------------------------------------------------------
// g3wf_pkg
// Shared constants, codes, types and helpers of the 3x3 gray window filter.
// ----------------------------------------------------------------------------
package g3wf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int OUT_COL_W = 10;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int TDATA_W   = 32;

  // compare widths for column and row counters against the image size
  localparam int CW_W = (COL_W + 1 > WREG_W) ? COL_W + 1 : WREG_W;
  localparam int RH_W = (ROW_W + 1 > HREG_W) ? ROW_W + 1 : HREG_W;

  localparam int SUM_W  = 12;
  localparam int NSUM_W = 10;
  localparam int PROD_W = 24;

  // floor(x / 9) == (x * 3641) >> 15 for every x up to 2295
  localparam logic [SUM_W-1:0] RECIP    = 12'd3641;
  localparam int               RECIP_SH = 15;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_BOX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHARP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INV   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd3;

  typedef struct packed {
    logic                 frame_last;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic [PIX_W-1:0]     gray;
  } result_t;

  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } item_t;

  typedef struct packed {
    logic   push;
    logic   drop;
    entry_t entry;
  } win_out_t;

  typedef struct packed {
    logic pop;
    logic full;
  } q_stat_t;

  function automatic logic [PIX_W-1:0] inv_px(input logic [PIX_W-1:0] p,
                                              input logic [PIX_W-1:0] mg);
    return (p > mg) ? '0 : PIX_W'(mg - p);
  endfunction

endpackage

// ----- sv/g3wf_line_store.sv -----
// ----------------------------------------------------------------------------
// g3wf_line_store
// Upper and middle line stores with registered read and write-to-read bypass.
// ----------------------------------------------------------------------------
module g3wf_line_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [g3wf_pkg::COL_W-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [g3wf_pkg::COL_W-1:0]    wr_addr,
  input  logic [g3wf_pkg::PIX_W-1:0]    wr_pix,
  output logic [g3wf_pkg::PIX_W-1:0]    up,
  output logic [g3wf_pkg::PIX_W-1:0]    mid
);

  logic [g3wf_pkg::PIX_W-1:0] upper_mem  [g3wf_pkg::MAX_WIDTH];
  logic [g3wf_pkg::PIX_W-1:0] middle_mem [g3wf_pkg::MAX_WIDTH];

  logic [g3wf_pkg::PIX_W-1:0] up_q_r;
  logic [g3wf_pkg::PIX_W-1:0] mid_q_r;
  logic                       fwd_r;
  logic [g3wf_pkg::PIX_W-1:0] fwd_up_r;
  logic [g3wf_pkg::PIX_W-1:0] fwd_mid_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q_r  <= upper_mem[rd_addr];
      mid_q_r <= middle_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

  // bypass the entry being written while the same entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_up_r  <= mid;
    fwd_mid_r <= wr_pix;
  end

  assign up  = fwd_r ? fwd_up_r  : up_q_r;
  assign mid = fwd_r ? fwd_mid_r : mid_q_r;

endmodule

// ----- sv/g3wf_window.sv -----
// ----------------------------------------------------------------------------
// g3wf_window
// 3x3 window registers, window arithmetic and result assembly per item.
// ----------------------------------------------------------------------------
module g3wf_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  g3wf_pkg::item_t                   s1,
  input  logic [g3wf_pkg::PIX_W-1:0]        up,
  input  logic [g3wf_pkg::PIX_W-1:0]        mid,
  input  logic [g3wf_pkg::CW_W-1:0]         w_eff,
  input  logic [g3wf_pkg::RH_W-1:0]         h_eff,
  input  logic [g3wf_pkg::PIX_W-1:0]        max_gray,
  input  logic [g3wf_pkg::MODE_W-1:0]       mode,
  output g3wf_pkg::win_out_t                win_out
);

  localparam int PIX_W     = g3wf_pkg::PIX_W;
  localparam int ROW_W     = g3wf_pkg::ROW_W;
  localparam int COL_W     = g3wf_pkg::COL_W;
  localparam int OUT_COL_W = g3wf_pkg::OUT_COL_W;
  localparam int CW_W      = g3wf_pkg::CW_W;
  localparam int RH_W      = g3wf_pkg::RH_W;
  localparam int SUM_W     = g3wf_pkg::SUM_W;
  localparam int NSUM_W    = g3wf_pkg::NSUM_W;
  localparam int PROD_W    = g3wf_pkg::PROD_W;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pix;
    logic [2:0]       has;
    logic [2:0]       last;
    logic             border0;
  } pos_t;

  logic [PIX_W-1:0] win_r [9];

  pos_t              s2_r;
  pos_t              s2_nxt;
  pos_t              s3_r;
  logic [SUM_W-1:0]  sum9_r;
  logic [NSUM_W-1:0] nsum4_r;
  logic [PIX_W-1:0]  centre_r;

  // slide the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1.valid) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= up;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1.pix;
    end
  end

  logic r_nz, c_nz, r_ge_h, c_ge_w;

  always_comb begin
    r_nz   = (s1.row != '0);
    c_nz   = (s1.col != '0);
    r_ge_h = (RH_W'(s1.row) >= h_eff);
    c_ge_w = (CW_W'(s1.col) >= w_eff);
    s2_nxt.valid   = s1.valid;
    s2_nxt.row     = s1.row;
    s2_nxt.col     = s1.col;
    s2_nxt.mid     = mid;
    s2_nxt.pix     = s1.pix;
    s2_nxt.has     = {s1.last_row, r_nz && s1.last_col, r_nz && c_nz};
    s2_nxt.last    = {s1.last_row && s1.last_col, r_ge_h && s1.last_col, r_ge_h && c_ge_w};
    s2_nxt.border0 = (s1.row == ROW_W'(1)) || (s1.col == COL_W'(1)) || r_ge_h || c_ge_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s2_r <= s2_nxt;
      s3_r <= s2_r;
    end
  end

  // sums over the window after this item's shift
  always_ff @(posedge clk) begin
    sum9_r   <= (SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2]))
              + (SUM_W'(win_r[3]) + SUM_W'(win_r[4]) + SUM_W'(win_r[5]))
              + (SUM_W'(win_r[6]) + SUM_W'(win_r[7]) + SUM_W'(win_r[8]));
    nsum4_r  <= (NSUM_W'(win_r[1]) + NSUM_W'(win_r[3]))
              + (NSUM_W'(win_r[5]) + NSUM_W'(win_r[7]));
    centre_r <= win_r[4];
  end

  logic [NSUM_W-1:0]     four_c;
  logic [NSUM_W-1:0]     lap_abs;
  logic [SUM_W-1:0]      dvd;
  logic [PROD_W-1:0]     prod;
  logic [PIX_W-1:0]      quot;
  logic [SUM_W-1:0]      ten_c;
  logic [SUM_W:0]        sharp;
  logic [PIX_W-1:0]      sharp_v;
  logic [PIX_W-1:0]      win_val;
  logic [PIX_W-1:0]      v0, v1, v2;
  g3wf_pkg::result_t     r0, r1, r2;
  g3wf_pkg::entry_t      entry;

  always_comb begin
    four_c  = {centre_r, 2'b00};
    lap_abs = (four_c >= nsum4_r) ? NSUM_W'(four_c - nsum4_r) : NSUM_W'(nsum4_r - four_c);
    dvd     = (mode == g3wf_pkg::MODE_BOX) ? sum9_r : SUM_W'(lap_abs);
    prod    = PROD_W'(dvd) * PROD_W'(g3wf_pkg::RECIP);
    quot    = prod[g3wf_pkg::RECIP_SH +: PIX_W];

    ten_c   = SUM_W'({centre_r, 3'b000}) + SUM_W'({centre_r, 1'b0});
    sharp   = {1'b0, ten_c} - {1'b0, sum9_r};
    if (sharp[SUM_W]) begin
      sharp_v = '0;
    end else if (sharp[SUM_W-1:0] > SUM_W'(max_gray)) begin
      sharp_v = max_gray;
    end else begin
      sharp_v = sharp[PIX_W-1:0];
    end

    unique case (mode)
      g3wf_pkg::MODE_BOX:   win_val = quot;
      g3wf_pkg::MODE_EDGE:  win_val = quot;
      g3wf_pkg::MODE_SHARP: win_val = sharp_v;
      g3wf_pkg::MODE_INV:   win_val = g3wf_pkg::inv_px(centre_r, max_gray);
      default:              win_val = '0;
    endcase

    if (mode == g3wf_pkg::MODE_INV) begin
      v0 = win_val;
      v1 = g3wf_pkg::inv_px(s3_r.mid, max_gray);
      v2 = g3wf_pkg::inv_px(s3_r.pix, max_gray);
    end else begin
      v0 = s3_r.border0 ? '0 : win_val;
      v1 = '0;
      v2 = '0;
    end

    r0.gray       = v0;
    r0.row        = ROW_W'(s3_r.row - ROW_W'(1));
    r0.col        = OUT_COL_W'(COL_W'(s3_r.col - COL_W'(1)));
    r0.frame_last = s3_r.last[0];
    r1.gray       = v1;
    r1.row        = ROW_W'(s3_r.row - ROW_W'(1));
    r1.col        = OUT_COL_W'(s3_r.col);
    r1.frame_last = s3_r.last[1];
    r2.gray       = v2;
    r2.row        = s3_r.row;
    r2.col        = OUT_COL_W'(s3_r.col);
    r2.frame_last = s3_r.last[2];

    // pack present results to the low slots
    entry.cnt    = 2'(s3_r.has[0]) + 2'(s3_r.has[1]) + 2'(s3_r.has[2]);
    entry.res[0] = s3_r.has[0] ? r0 : (s3_r.has[1] ? r1 : r2);
    entry.res[1] = (s3_r.has[0] && s3_r.has[1]) ? r1 : r2;
    entry.res[2] = r2;

    win_out.push  = s3_r.valid && (s3_r.has != 3'b000);
    win_out.drop  = s3_r.valid && (s3_r.has == 3'b000);
    win_out.entry = entry;
  end

endmodule

// ----- sv/g3wf_out_queue.sv -----
// ----------------------------------------------------------------------------
// g3wf_out_queue
// Queue of per-item result groups, serialized into one output register.
// ----------------------------------------------------------------------------
module g3wf_out_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  g3wf_pkg::win_out_t                 win_out,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [g3wf_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tlast,
  output g3wf_pkg::q_stat_t                  q_stat
);

  localparam int Q_DEPTH = g3wf_pkg::Q_DEPTH;
  localparam int Q_AW    = g3wf_pkg::Q_AW;
  localparam int Q_CNT_W = g3wf_pkg::Q_CNT_W;
  localparam int RES_W   = $bits(g3wf_pkg::result_t) - 1;

  g3wf_pkg::entry_t  q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [1:0]        slot_r;
  logic              out_valid_r;
  g3wf_pkg::result_t out_res_r;

  g3wf_pkg::entry_t  head;
  g3wf_pkg::result_t cur;
  logic              load;
  logic              pop;

  always_comb begin
    head = q_mem[rd_ptr_r];
    cur  = head.res[slot_r];
    load = (cnt_r != '0) && (!out_valid_r || out_tready);
    pop  = load && (2'(slot_r + 2'd1) == head.cnt);
  end

  always_ff @(posedge clk) begin
    if (win_out.push) begin
      q_mem[wr_ptr_r] <= win_out.entry;
    end
    if (load) begin
      out_res_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (win_out.push) begin
        wr_ptr_r <= Q_AW'(wr_ptr_r + Q_AW'(1));
      end
      if (pop) begin
        rd_ptr_r <= Q_AW'(rd_ptr_r + Q_AW'(1));
        slot_r   <= '0;
      end else if (load) begin
        slot_r <= 2'(slot_r + 2'd1);
      end
      cnt_r <= Q_CNT_W'(cnt_r + Q_CNT_W'(win_out.push) - Q_CNT_W'(pop));
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = g3wf_pkg::TDATA_W'(out_res_r[RES_W-1:0]);
  assign out_tlast   = out_res_r.frame_last;
  assign q_stat.pop  = pop;
  assign q_stat.full = (cnt_r == Q_CNT_W'(Q_DEPTH));

endmodule

// ----- sv/grayscale_3x3_window_filter.sv -----
// ----------------------------------------------------------------------------
// grayscale_3x3_window_filter
// 3x3 box / Laplacian edge / sharpen / invert filter over a raster stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream, one gray value per item, in raster order.
// Each item yields zero to three result items on the out_ stream: the window
// centre one row and one column behind, plus the border positions that the
// last column and the last row close. tlast marks the last pixel of a frame.
// The cfg_ channel writes image width, height, max gray and filter mode by
// index; cfg_ready is always high. Write it only while the block is idle.
// One item is accepted per cycle while in_tready is high. Its first result
// passes the s1, s2 and s3 registers and the output queue to out_tvalid;
// items with two or three results leave one at a time. The line stores are
// two single-port-read memories read in the accept cycle and written in the
// cycle after, with a bypass for the same column. An eight-group output queue
// with credit counting holds results, so input keeps flowing while the
// receiver stalls until the queue fills; then in_tready drops. Reset clears
// counters, window, queue and registers to width 1024, height 1024, max gray
// 255, box mode; line stores need no clearing: unwritten entries reach no result.
// ----------------------------------------------------------------------------
module grayscale_3x3_window_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [g3wf_pkg::PIX_W-1:0]         in_tdata,   // [7:0] gray_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [g3wf_pkg::TDATA_W-1:0]       out_tdata,  // [7:0] gray_out,
                                                         // [19:8] out_row,
                                                         // [29:20] out_col
  output logic                               out_tlast,  // frame_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [g3wf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [g3wf_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int PIX_W   = g3wf_pkg::PIX_W;
  localparam int COL_W   = g3wf_pkg::COL_W;
  localparam int ROW_W   = g3wf_pkg::ROW_W;
  localparam int WREG_W  = g3wf_pkg::WREG_W;
  localparam int HREG_W  = g3wf_pkg::HREG_W;
  localparam int CW_W    = g3wf_pkg::CW_W;
  localparam int RH_W    = g3wf_pkg::RH_W;
  localparam int Q_CNT_W = g3wf_pkg::Q_CNT_W;

  logic [WREG_W-1:0]           width_r;
  logic [HREG_W-1:0]           height_r;
  logic [PIX_W-1:0]            max_gray_r;
  logic [g3wf_pkg::MODE_W-1:0] mode_r;

  logic [CW_W-1:0] w_eff;
  logic [RH_W-1:0] h_eff;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [Q_CNT_W-1:0] credit_r, credit_nxt;
  g3wf_pkg::item_t    s1_r;

  logic               in_fire;
  logic               last_col, last_row;
  logic [PIX_W-1:0]   up, mid;
  g3wf_pkg::win_out_t win_out;
  g3wf_pkg::q_stat_t  q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WREG_W'(1024);
      height_r   <= HREG_W'(1024);
      max_gray_r <= PIX_W'(255);
      mode_r     <= g3wf_pkg::MODE_BOX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        g3wf_pkg::CFG_WIDTH:    width_r    <= cfg_data[WREG_W-1:0];
        g3wf_pkg::CFG_HEIGHT:   height_r   <= cfg_data[HREG_W-1:0];
        g3wf_pkg::CFG_MAX_GRAY: max_gray_r <= cfg_data[PIX_W-1:0];
        g3wf_pkg::CFG_MODE:     mode_r     <= cfg_data[g3wf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = CW_W'(1);
    end else if (CW_W'(width_r) > CW_W'(g3wf_pkg::MAX_WIDTH)) begin
      w_eff = CW_W'(g3wf_pkg::MAX_WIDTH);
    end else begin
      w_eff = CW_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RH_W'(1);
    end else if (RH_W'(height_r) > RH_W'(g3wf_pkg::MAX_HEIGHT)) begin
      h_eff = RH_W'(g3wf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RH_W'(height_r);
    end
  end

  assign in_tready = (credit_r < Q_CNT_W'(g3wf_pkg::Q_DEPTH));
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    last_col = (CW_W'(CW_W'(col_r) + CW_W'(1)) >= w_eff);
    last_row = (RH_W'(RH_W'(row_r) + RH_W'(1)) >= h_eff);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : ROW_W'(row_r + ROW_W'(1));
    end else begin
      col_nxt = COL_W'(col_r + COL_W'(1));
      row_nxt = row_r;
    end
    credit_nxt = Q_CNT_W'(credit_r + Q_CNT_W'(in_fire)
                          - Q_CNT_W'(win_out.drop) - Q_CNT_W'(q_stat.pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      credit_r <= '0;
      s1_r     <= '0;
    end else begin
      if (in_fire) begin
        row_r         <= row_nxt;
        col_r         <= col_nxt;
        s1_r.pix      <= in_tdata;
        s1_r.row      <= row_r;
        s1_r.col      <= col_r;
        s1_r.last_col <= last_col;
        s1_r.last_row <= last_row;
      end
      credit_r   <= credit_nxt;
      s1_r.valid <= in_fire;
    end
  end

  g3wf_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .wr_en   (s1_r.valid),
    .wr_addr (s1_r.col),
    .wr_pix  (s1_r.pix),
    .up      (up),
    .mid     (mid)
  );

  g3wf_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1_r),
    .up       (up),
    .mid      (mid),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .max_gray (max_gray_r),
    .mode     (mode_r),
    .win_out  (win_out)
  );

  g3wf_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_out    (win_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .q_stat     (q_stat)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= Q_CNT_W'(g3wf_pkg::Q_DEPTH))
    else $error("credit count above queue depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(win_out.push && q_stat.full && !q_stat.pop))
    else $error("result group pushed into a full queue");

  a_pop_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.pop |-> (credit_r != '0))
    else $error("queue pop without an outstanding item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
